[hdl/caspar_pkg.sv]
// Package for the colour attribute string parser: character classes,
// flag bits and the colour name table. It depends on nothing else.
`default_nettype none

package caspar_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned AttrWidth = 16;
   localparam int unsigned ColorWidth = 3;

   localparam logic [AttrWidth-1:0] DefaultAttrReset = 16'h0007;
   localparam logic [AttrWidth-1:0] BlinkBit = 16'h0080;
   localparam logic [AttrWidth-1:0] IntenseBit = 16'h0100;

   localparam logic [CharWidth-1:0] ChTerm = 8'h00;
   localparam logic [CharWidth-1:0] ChStar = 8'h2A;
   localparam logic [CharWidth-1:0] ChQuery = 8'h3F;
   localparam logic [CharWidth-1:0] ChMinus = 8'h2D;
   localparam logic [CharWidth-1:0] ChPlus = 8'h2B;
   localparam logic [CharWidth-1:0] ChSlash = 8'h2F;
   localparam logic [CharWidth-1:0] ChZero = 8'h30;
   localparam logic [CharWidth-1:0] ChSeven = 8'h37;
   localparam logic [CharWidth-1:0] ChNine = 8'h39;

   localparam logic [ColorWidth-1:0] ColorWhite = 3'd7;

   // Three lowercase letters per name, first letter in the top byte.
   localparam logic [23:0] ColorNames [8] = '{
      24'h626C6B, // blk
      24'h626C75, // blu
      24'h67726E, // grn
      24'h63796E, // cyn
      24'h726564, // red
      24'h6D6167, // mag
      24'h79656C, // yel
      24'h776874  // wht
   };

   function automatic logic is_digit(input logic [CharWidth-1:0] c);
      return (c >= ChZero) && (c <= ChNine);
   endfunction

   function automatic logic is_alpha(input logic [CharWidth-1:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic [CharWidth-1:0] to_lower(input logic [CharWidth-1:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
   endfunction

   // Returns the colour index in the low bits and a hit flag in the top bit.
   function automatic logic [ColorWidth:0] lookup_name(input logic [23:0] name);
      logic [ColorWidth:0] result;
      result = '0;
      for (int k = 0; k < 8; k++) begin
         if (ColorNames[k] == name) begin
            result = {1'b1, ColorWidth'(k)};
         end
      end
      return result;
   endfunction

endpackage : caspar_pkg

`default_nettype wire

[hdl/color_attribute_string_parser.sv]
// Top level of the colour attribute string parser: a per-character state
// update and a result register with handshake. Depends on caspar_pkg.
//
// Usage: characters arrive on the req_ stream, one byte per transfer; a zero
// byte ends the string. Each string starts from the attribute held in the
// csr_ register (reset value 7), applies optional blink/intense flag
// characters, then an optional foreground colour, a slash and a background
// colour. Only the terminating zero produces a transfer on the rsp_ stream:
// rsp_tdata carries the attribute and rsp_tuser flags a malformed string
// (with rsp_tdata then zero).
// Throughput is one character per cycle. A result appears on rsp_ in the cycle
// after its terminator is taken, from a single output register. While that
// register holds a result the receiver has not taken, req_tready is low; it
// rises in the same cycle rsp_tready is seen, so a steady receiver never
// stalls the character stream. Synchronous reset clears the parse state,
// empties the output register and restores the default attribute. csr_
// writes are always taken and apply from the next string onwards.
`default_nettype none

module color_attribute_string_parser
   import caspar_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Configuration write channel.
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [AttrWidth-1:0] csr_data,   // default_attr
   // Character stream.
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [CharWidth-1:0] req_tdata,  // ch
   // Result stream.
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [AttrWidth-1:0] rsp_tdata,  // attr_out
   output      logic                 rsp_tuser   // error
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_PREFIX = 3'd1,
      PH_FGNAME = 3'd2,
      PH_SLASH  = 3'd3,
      PH_BG     = 3'd4,
      PH_BGNAME = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   phase_type             phase_ff, phase_in, ph_cur;
   logic [1:0]            count_ff, count_in, count_cur;
   logic [15:0]           letters_ff, letters_in, letters_cur;
   logic [AttrWidth-1:0]  work_ff, work_in, work_cur;
   logic [ColorWidth-1:0] fg_ff, fg_in, fg_cur;
   logic                  err_ff, err_in;
   logic [AttrWidth-1:0]  default_ff;

   logic                  rsp_valid_ff;
   logic [AttrWidth-1:0]  rsp_attr_ff, rsp_attr_in;
   logic                  rsp_err_ff, rsp_err_in;
   logic                  rsp_load;

   logic                  req_fire;
   logic [CharWidth-1:0]  ch;
   logic [CharWidth-1:0]  ch_low;
   logic                  ch_digit, ch_alpha;
   logic [ColorWidth-1:0] digit_val;
   logic [ColorWidth:0]   name_hit;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_attr_ff;
   assign rsp_tuser  = rsp_err_ff;

   assign ch        = req_tdata;
   assign ch_low    = to_lower(ch);
   assign ch_digit  = is_digit(ch);
   assign ch_alpha  = is_alpha(ch);
   assign digit_val = ch[ColorWidth-1:0];
   assign name_hit  = lookup_name({letters_ff, ch_low});

   // The first character of a string loads the default attribute.
   assign ph_cur      = (phase_ff == PH_IDLE) ? PH_PREFIX : phase_ff;
   assign work_cur    = (phase_ff == PH_IDLE) ? default_ff : work_ff;
   assign fg_cur      = (phase_ff == PH_IDLE) ? ColorWhite : fg_ff;
   assign count_cur   = (phase_ff == PH_IDLE) ? 2'd0 : count_ff;
   assign letters_cur = (phase_ff == PH_IDLE) ? 16'h0000 : letters_ff;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      letters_in  = letters_ff;
      work_in     = work_ff;
      fg_in       = fg_ff;
      err_in      = err_ff;
      rsp_load    = 1'b0;
      rsp_attr_in = rsp_attr_ff;
      rsp_err_in  = rsp_err_ff;

      if (req_fire) begin
         if (ch == ChTerm) begin
            rsp_load    = 1'b1;
            rsp_err_in  = err_ff;
            rsp_attr_in = err_ff ? '0 : ((phase_ff == PH_IDLE) ? default_ff : work_ff);
            phase_in    = PH_IDLE;
            count_in    = 2'd0;
            letters_in  = 16'h0000;
            fg_in       = ColorWhite;
            err_in      = 1'b0;
            work_in     = default_ff;
         end else if (!err_ff) begin
            phase_in   = ph_cur;
            count_in   = count_cur;
            letters_in = letters_cur;
            work_in    = work_cur;
            fg_in      = fg_cur;
            unique case (ph_cur)
               PH_PREFIX, PH_BG: begin
                  if (ph_cur == PH_PREFIX && ch == ChStar) begin
                     work_in = work_cur & ~BlinkBit;
                  end else if (ph_cur == PH_PREFIX && ch == ChQuery) begin
                     work_in = work_cur | BlinkBit;
                  end else if (ph_cur == PH_PREFIX && ch == ChMinus) begin
                     work_in = work_cur & ~IntenseBit;
                  end else if (ph_cur == PH_PREFIX && ch == ChPlus) begin
                     work_in = work_cur | IntenseBit;
                  end else if (ph_cur == PH_PREFIX && ch == ChSlash) begin
                     phase_in = PH_BG;
                  end else if (ch_digit) begin
                     if (ch > ChSeven) begin
                        err_in = 1'b1;
                     end else if (ph_cur == PH_PREFIX) begin
                        fg_in    = digit_val;
                        phase_in = PH_SLASH;
                     end else begin
                        work_in  = {work_cur[15:8], 2'b00, fg_cur, digit_val};
                        phase_in = PH_DONE;
                     end
                  end else if (ch_alpha) begin
                     letters_in = {ch_low, 8'h00};
                     count_in   = 2'd1;
                     phase_in   = (ph_cur == PH_PREFIX) ? PH_FGNAME : PH_BGNAME;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               PH_FGNAME, PH_BGNAME: begin
                  if (!ch_alpha) begin
                     err_in = 1'b1;
                  end else if (count_cur == 2'd1) begin
                     letters_in = {letters_cur[15:8], ch_low};
                     count_in   = 2'd2;
                  end else begin
                     count_in = 2'd0;
                     if (!name_hit[ColorWidth]) begin
                        err_in = 1'b1;
                     end else if (ph_cur == PH_FGNAME) begin
                        fg_in    = name_hit[ColorWidth-1:0];
                        phase_in = PH_SLASH;
                     end else begin
                        work_in  = {work_cur[15:8], 2'b00, fg_cur,
                                    name_hit[ColorWidth-1:0]};
                        phase_in = PH_DONE;
                     end
                  end
               end
               PH_SLASH: begin
                  if (ch == ChSlash) begin
                     phase_in = PH_BG;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= 2'd0;
         letters_ff   <= 16'h0000;
         work_ff      <= DefaultAttrReset;
         fg_ff        <= ColorWhite;
         err_ff       <= 1'b0;
         default_ff   <= DefaultAttrReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         letters_ff <= letters_in;
         work_ff    <= work_in;
         fg_ff      <= fg_in;
         err_ff     <= err_in;
         if (csr_valid) begin
            default_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_attr_ff <= rsp_attr_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

endmodule : color_attribute_string_parser

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for color_attribute_string_parser: a line-level
// predictor, a character sender, a stalling receiver and a result checker.
// Depends on caspar_pkg and the parser RTL only.

module tb_top;
   import caspar_pkg::*;

   localparam int unsigned ItemTarget = 1150;
   localparam int unsigned IdleLimit = 2000;

   localparam logic [AttrWidth-1:0] ResetDefault = 16'h0007;
   localparam logic [AttrWidth-1:0] BlinkMask = 16'h0080;
   localparam logic [AttrWidth-1:0] IntenseMask = 16'h0100;

   localparam logic [7:0] CharEnd = 8'h00;
   localparam logic [7:0] CharBlinkOff = "*";
   localparam logic [7:0] CharBlinkOn = "?";
   localparam logic [7:0] CharBrightOff = "-";
   localparam logic [7:0] CharBrightOn = "+";
   localparam logic [7:0] CharSlash = "/";
   localparam logic [7:0] CharDigitZero = "0";
   localparam logic [7:0] CharDigitEight = "8";
   localparam logic [7:0] CharLowerA = "a";

   localparam logic [7:0] FlagChars [4] = '{CharBlinkOff, CharBlinkOn, CharBrightOff,
                                            CharBrightOn};
   localparam logic [23:0] HueNames [8] = '{"blk", "blu", "grn", "cyn",
                                            "red", "mag", "yel", "wht"};

   typedef enum logic [2:0] {
      PhStart,
      PhFlags,
      PhFgName,
      PhSlash,
      PhBg,
      PhBgName,
      PhTrailer
   } parse_phase_type;

   typedef struct packed {
      logic [AttrWidth-1:0] attr;
      logic                 bad;
   } outcome_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [AttrWidth-1:0] csr_data;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [CharWidth-1:0] req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [AttrWidth-1:0] rsp_tdata;
   logic                 rsp_tuser;

   // Parser state as the checker expects it.
   logic [AttrWidth-1:0] dflt_m;
   logic [AttrWidth-1:0] work_m;
   parse_phase_type      phase_m;
   logic [1:0]           letters_m;
   logic [15:0]          name_m;
   logic [2:0]           fg_m;
   logic                 err_m;

   outcome_type outcomes_due [$];
   logic [7:0]  line [$];
   int unsigned failures = 0;
   int unsigned results_seen = 0;
   int unsigned strings_sent = 0;
   int unsigned bad_strings = 0;
   int unsigned chars_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned rx_hold = 0;
   bit          tx_idling = 1'b0;
   bit          rx_idling = 1'b0;

   color_attribute_string_parser dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic is_dec(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
   endfunction

   function automatic void start_fresh();
      phase_m = PhStart;
      letters_m = '0;
      name_m = '0;
      fg_m = 3'd7;
      err_m = 1'b0;
      work_m = dflt_m;
   endfunction

   function automatic void set_background(input logic [2:0] bg);
      work_m = {work_m[15:8], 2'b00, fg_m, bg};
      phase_m = PhTrailer;
   endfunction

   function automatic void take_color(input logic [7:0] c, input logic is_fg);
      logic [7:0] d;
      d = c - CharDigitZero;
      if (is_dec(c)) begin
         if (d > 8'd7) begin
            err_m = 1'b1;
         end else if (is_fg) begin
            fg_m = d[2:0];
            phase_m = PhSlash;
         end else begin
            set_background(d[2:0]);
         end
      end else if (is_letter(c)) begin
         name_m = {fold_case(c), 8'h00};
         letters_m = 2'd1;
         phase_m = is_fg ? PhFgName : PhBgName;
      end else begin
         err_m = 1'b1;
      end
   endfunction

   function automatic void take_name_letter(input logic [7:0] c, input logic is_fg);
      logic       found;
      logic [2:0] hue;
      int         k;
      found = 1'b0;
      hue = '0;
      if (!is_letter(c)) begin
         err_m = 1'b1;
      end else if (letters_m == 2'd1) begin
         name_m[7:0] = fold_case(c);
         letters_m = 2'd2;
      end else begin
         for (k = 0; k < 8; k++) begin
            if (HueNames[k] == {name_m, fold_case(c)}) begin
               found = 1'b1;
               hue = k[2:0];
            end
         end
         letters_m = '0;
         if (!found) begin
            err_m = 1'b1;
         end else if (is_fg) begin
            fg_m = hue;
            phase_m = PhSlash;
         end else begin
            set_background(hue);
         end
      end
   endfunction

   function automatic void predict_char(input logic [7:0] c);
      if (c == CharEnd) begin
         // A string with no characters reports the default as it is now.
         if (err_m) begin
            outcomes_due.push_back('{attr: '0, bad: 1'b1});
            bad_strings++;
         end else begin
            outcomes_due.push_back('{attr: (phase_m == PhStart) ? dflt_m : work_m, bad: 1'b0});
         end
         strings_sent++;
         start_fresh();
         return;
      end
      if (err_m) return;
      if (phase_m == PhStart) begin
         work_m = dflt_m;
         fg_m = 3'd7;
         letters_m = '0;
         name_m = '0;
         phase_m = PhFlags;
      end
      case (phase_m)
         PhFlags: begin
            if (c == CharBlinkOff) work_m = work_m & ~BlinkMask;
            else if (c == CharBlinkOn) work_m = work_m | BlinkMask;
            else if (c == CharBrightOff) work_m = work_m & ~IntenseMask;
            else if (c == CharBrightOn) work_m = work_m | IntenseMask;
            else if (c == CharSlash) phase_m = PhBg;
            else if (is_dec(c) || is_letter(c)) take_color(c, 1'b1);
            else err_m = 1'b1;
         end
         PhFgName: take_name_letter(c, 1'b1);
         PhSlash: begin
            if (c == CharSlash) phase_m = PhBg;
            else err_m = 1'b1;
         end
         PhBg: take_color(c, 1'b0);
         PhBgName: take_name_letter(c, 1'b0);
         default: err_m = 1'b1;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else if (rx_idling && ($urandom_range(0, 99) < 25)) begin
         rsp_tready <= 1'b0;
         rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (outcomes_due.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, actual attr %h error %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_tdata !== want.attr) begin
               failures++;
               $display("%0t: attr_out mismatch, expected %h, actual %h",
                        $time, want.attr, rsp_tdata);
            end
            if (rsp_tuser !== want.bad) begin
               failures++;
               $display("%0t: error flag mismatch, expected %b, actual %b",
                        $time, want.bad, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IdleLimit) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, outcomes_due.size());
            $display("FAIL color_attribute_string_parser");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender and configuration
   // ------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!tx_idling) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic void pick_idling(input logic [1:0] mode);
      tx_idling = mode[0];
      rx_idling = mode[1];
   endfunction

   task automatic send_char(input logic [7:0] c);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_char(c);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(CharEnd);
   endtask

   task automatic send_line();
      for (int i = 0; i < line.size(); i++) send_char(line[i]);
      send_char(CharEnd);
      line.delete();
   endtask

   // The sender holds back until every outstanding result has been taken.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic change_default(input logic [AttrWidth-1:0] value);
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      dflt_m = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Line builders
   // ------------------------------------------------------------------
   function automatic logic [7:0] mixed_case(input logic [7:0] c);
      return $urandom_range(0, 1) ? c - 8'd32 : c;
   endfunction

   function automatic void add_color();
      logic [2:0]  hue;
      logic [23:0] nm;
      hue = 3'($urandom_range(0, 7));
      nm = HueNames[hue];
      if ($urandom_range(0, 1)) begin
         line.push_back(CharDigitZero + 8'(hue));
      end else begin
         line.push_back(mixed_case(nm[23:16]));
         line.push_back(mixed_case(nm[15:8]));
         line.push_back(mixed_case(nm[7:0]));
      end
   endfunction

   function automatic void damage_line();
      int unsigned pos;
      pos = $urandom_range(0, line.size());
      case ($urandom_range(0, 5))
         0: line.insert(pos, 8'($urandom_range(1, 255)));
         1: begin
            if (line.size() > 0) line[$urandom_range(0, line.size() - 1)] =
               8'($urandom_range(1, 255));
            else line.push_back(8'($urandom_range(128, 255)));
         end
         2: repeat ($urandom_range(1, 2)) if (line.size() > 0) void'(line.pop_back());
         3: line.push_back(8'($urandom_range(1, 255)));
         4: line.insert(pos, CharDigitEight + 8'($urandom_range(0, 1)));
         default: begin
            // Three random letters: almost never a real colour name.
            repeat (3) line.insert(pos, mixed_case(CharLowerA + 8'($urandom_range(0, 25))));
         end
      endcase
   endfunction

   function automatic void build_line();
      int unsigned form;
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(1, 255)));
         return;
      end
      repeat ($urandom_range(0, 3)) line.push_back(FlagChars[$urandom_range(0, 3)]);
      form = $urandom_range(0, 9);
      if ((form >= 1) && (form <= 7)) add_color();
      if (form >= 2) begin
         line.push_back(CharSlash);
         add_color();
      end
      if ($urandom_range(0, 3) == 0) damage_line();
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      pick_idling(2'b00);
      send_text("");
      send_text("?+7/0");
      send_text("*-Red/CyN");
      send_text("8");
      send_char(8'hFF);
      send_char(CharEnd);
      send_text("5!");
   endtask

   task automatic test_default_register();
      logic [AttrWidth-1:0] values [5];
      values = '{16'h0000, 16'hFFFF, 16'h0180, 16'hFE7F, 16'h0000};
      values[4] = 16'($urandom_range(0, 16'hFFFF));
      pick_idling(2'b11);
      foreach (values[i]) begin
         change_default(values[i]);
         send_text("");
         send_text("*-");
         send_text("?+");
         repeat (4) begin
            build_line();
            send_line();
         end
      end
   endtask

   task automatic test_random_strings();
      int unsigned lines;
      lines = 0;
      while (chars_sent < ItemTarget) begin
         if (lines % 50 == 0) pick_idling(2'($urandom_range(0, 3)));
         if (lines % 180 == 179) change_default(16'($urandom_range(0, 16'hFFFF)));
         build_line();
         send_line();
         lines++;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      dflt_m = ResetDefault;
      start_fresh();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_default_register();
      test_random_strings();

      pick_idling(2'b00);
      wait_for_results();
      $display("Sent %0d strings (%0d malformed) in %0d characters; %0d results checked.",
               strings_sent, bad_strings, chars_sent, results_seen);
      $display("Flag prefixes, digit and named colours, broken input and several defaults.");
      if (failures == 0) begin
         $display("PASS color_attribute_string_parser");
      end else begin
         $display("FAIL color_attribute_string_parser");
      end
      $finish;
   end

endmodule
